/* hw/rtl/vsl_pkg.sv */
// vsl_pkg: shared types and constants of the voxel sphere level stamp.
// Used by vsl_ctrl, vsl_dp and voxel_sphere_level_stamp; depends on nothing.
`default_nettype none

package vsl_pkg;

  localparam int unsigned COORD_W    = 6;   // cell coordinate fields
  localparam int unsigned GSZ_W      = 7;   // grid_size register
  localparam int unsigned NLV_W      = 4;   // num_levels register
  localparam int unsigned LVL_W      = 3;   // one stored level
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned MCNT_W     = $clog2(COORD_W);

  localparam logic [LVL_W-1:0] LEVEL_TOP      = 3'd7;
  localparam logic [GSZ_W-1:0] GRID_SIZE_RST  = 7'd64;
  localparam logic [NLV_W-1:0] NUM_LEVELS_RST = 4'd8;
  localparam logic [LVL_W-1:0] BASE_LEVEL_RST = 3'd0;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL = 2'd2;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_STAMP = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef struct packed {
    logic clr_start;   // latch fill value, address to zero
    logic clr_zero;    // fill with zero instead of base_level
    logic clr_step;    // write one cell of the sweep
    logic load;        // take coordinates and config snapshot
    logic mod_step;    // one remainder step on all three axes
    logic dec_step;    // move start corner back by one cell
    logic mul1;        // g*g and g*y
    logic mul2;        // g*g*z
    logic walk_step;   // issue one stamp cell
    logic rd_issue;    // issue the read request
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic dec_done;
    logic walk_last;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/vsl_ctrl.sv */
// vsl_ctrl: sequencer of the voxel sphere level stamp.
// Depends on vsl_pkg; drives vsl_dp through cmd_t and watches sts_t.
`default_nettype none

module vsl_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [1:0]           func_i,
  output logic                      busy_o,
  output vsl_pkg::cmd_t             cmd_o,
  input  wire vsl_pkg::sts_t        sts_i
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_DEC,
    ST_MUL1,
    ST_MUL2,
    ST_WALK,
    ST_READ,
    ST_DRAIN1,
    ST_DRAIN2
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   stamp_q, stamp_d;

  always_comb begin
    state_d = state_q;
    stamp_d = stamp_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        // reset sweep: the whole grid goes to zero
        cmd_o.clr_start = 1'b1;
        cmd_o.clr_zero  = 1'b1;
        state_d         = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          case (func_i)
            vsl_pkg::FUNC_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = ST_CLEAR;
            end
            vsl_pkg::FUNC_STAMP: begin
              cmd_o.load = 1'b1;
              stamp_d    = 1'b1;
              state_d    = ST_MOD;
            end
            vsl_pkg::FUNC_READ: begin
              cmd_o.load = 1'b1;
              stamp_d    = 1'b0;
              state_d    = ST_MOD;
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = stamp_q ? ST_DEC : ST_MUL1;
      end
      ST_DEC: begin
        if (sts_i.dec_done) state_d = ST_MUL1;
        else cmd_o.dec_step = 1'b1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = stamp_q ? ST_WALK : ST_READ;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) state_d = ST_DRAIN1;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_DRAIN1;
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      busy_q  <= 1'b1;
      stamp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      stamp_q <= stamp_d;
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

/* hw/rtl/vsl_dp.sv */
// vsl_dp: datapath of the voxel sphere level stamp: config registers,
// coordinate reduction, stamp walk, level memory and its RMW pipeline.
// Depends on vsl_pkg; commanded by vsl_ctrl.
`default_nettype none

module vsl_dp #(
  parameter int GRID_SIDE  = 64,
  parameter int MAX_LEVELS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire vsl_pkg::cmd_t                     cmd_i,
  output vsl_pkg::sts_t                          sts_o,
  input  wire logic [vsl_pkg::COORD_W-1:0]       cell_x_i,
  input  wire logic [vsl_pkg::COORD_W-1:0]       cell_y_i,
  input  wire logic [vsl_pkg::COORD_W-1:0]       cell_z_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [vsl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [vsl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                   valid_o,
  output logic [vsl_pkg::LVL_W-1:0]              level_o
);

  localparam int GW         = vsl_pkg::GSZ_W;
  localparam int CW         = vsl_pkg::COORD_W;
  localparam int LW         = vsl_pkg::LVL_W;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int EMAX       = MAX_LEVELS - 2;
  localparam int EW         = (EMAX > 0) ? $clog2(EMAX + 1) : 1;
  localparam int SW         = $clog2(2 * EMAX + 2);
  localparam int DW         = $clog2(EMAX + 2);
  localparam int R2MAX      = 3 * EMAX * EMAX;
  localparam int R2W        = (R2MAX > 0) ? $clog2(R2MAX + 1) : 1;

  // configuration registers
  logic [GW-1:0]             grid_size_q;
  logic [vsl_pkg::NLV_W-1:0] num_levels_q;
  logic [LW-1:0]             base_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q  <= vsl_pkg::GRID_SIZE_RST;
      num_levels_q <= vsl_pkg::NUM_LEVELS_RST;
      base_level_q <= vsl_pkg::BASE_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vsl_pkg::CFG_GRID_SIZE:  grid_size_q  <= cfg_data_i[GW-1:0];
        vsl_pkg::CFG_NUM_LEVELS: num_levels_q <= cfg_data_i[vsl_pkg::NLV_W-1:0];
        vsl_pkg::CFG_BASE_LEVEL: base_level_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // effective grid side and stamp extent
  logic [GW-1:0] g_sat;
  logic [EW-1:0] e_sat;

  always_comb begin
    if (grid_size_q == '0) g_sat = GW'(1);
    else if (int'(grid_size_q) > GRID_SIDE) g_sat = GW'(GRID_SIDE);
    else g_sat = grid_size_q;
    if (num_levels_q < vsl_pkg::NLV_W'(2)) e_sat = '0;
    else if (int'(num_levels_q) > MAX_LEVELS) e_sat = EW'(EMAX);
    else e_sat = EW'(num_levels_q - vsl_pkg::NLV_W'(2));
  end

  // walk registers
  logic [GW-1:0]       g_q;
  logic [EW-1:0]       e_q;
  logic [CW-1:0]       xin_q, yin_q, zin_q;
  logic [vsl_pkg::MCNT_W-1:0] mcnt_q;
  logic [GW-1:0]       x_q, y_q, z_q;
  logic [GW-1:0]       xs_q, ys_q;
  logic [2*GW-1:0]     g2_q;
  logic [AW-1:0]       yt_q, zt_q, yts_q;
  logic [SW-1:0]       a_q, b_q, c_q;

  logic [GW-1:0]   g_m1;
  logic [SW-1:0]   e_w, e2_w;
  logic            a_last, b_last, c_last;
  logic [2*GW-1:0] prod_gg, prod_gy;
  logic [3*GW-1:0] prod_gz;
  logic [GW:0]     shx, shy, shz;

  assign g_m1    = g_q - GW'(1);
  assign e_w     = SW'(e_q);
  assign e2_w    = SW'({e_q, 1'b0});
  assign a_last  = (a_q == e2_w);
  assign b_last  = (b_q == e2_w);
  assign c_last  = (c_q == e2_w);
  assign prod_gg = (2*GW)'(g_q) * (2*GW)'(g_q);
  assign prod_gy = (2*GW)'(g_q) * (2*GW)'(y_q);
  assign prod_gz = (3*GW)'(g2_q) * (3*GW)'(z_q);

  // restoring remainder, one coordinate bit per step
  assign shx = {x_q, xin_q[CW-1]};
  assign shy = {y_q, yin_q[CW-1]};
  assign shz = {z_q, zin_q[CW-1]};

  function automatic logic [GW-1:0] rem_step(logic [GW:0] sh, logic [GW-1:0] g);
    logic [GW:0] gx;
    gx = {1'b0, g};
    if (sh >= gx) return GW'(sh - gx);
    return GW'(sh);
  endfunction

  function automatic logic [GW-1:0] dec_wrap(logic [GW-1:0] p, logic [GW-1:0] gm1);
    if (p == '0) return gm1;
    return p - GW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      g_q    <= g_sat;
      e_q    <= e_sat;
      xin_q  <= cell_x_i;
      yin_q  <= cell_y_i;
      zin_q  <= cell_z_i;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      mcnt_q <= '0;
      a_q    <= '0;
    end
    if (cmd_i.mod_step) begin
      x_q    <= rem_step(shx, g_q);
      y_q    <= rem_step(shy, g_q);
      z_q    <= rem_step(shz, g_q);
      xin_q  <= xin_q << 1;
      yin_q  <= yin_q << 1;
      zin_q  <= zin_q << 1;
      mcnt_q <= mcnt_q + vsl_pkg::MCNT_W'(1);
    end
    if (cmd_i.dec_step) begin
      x_q <= dec_wrap(x_q, g_m1);
      y_q <= dec_wrap(y_q, g_m1);
      z_q <= dec_wrap(z_q, g_m1);
      a_q <= a_q + SW'(1);
    end
    if (cmd_i.mul1) begin
      g2_q <= prod_gg;
      yt_q <= AW'(prod_gy);
      xs_q <= x_q;
      ys_q <= y_q;
      a_q  <= '0;
      b_q  <= '0;
      c_q  <= '0;
    end
    if (cmd_i.mul2) begin
      zt_q  <= AW'(prod_gz);
      yts_q <= yt_q;
    end
    if (cmd_i.walk_step) begin
      if (!a_last) begin
        a_q <= a_q + SW'(1);
        x_q <= (x_q == g_m1) ? '0 : x_q + GW'(1);
      end else begin
        a_q <= '0;
        x_q <= xs_q;
        if (!b_last) begin
          b_q <= b_q + SW'(1);
          if (y_q == g_m1) begin
            y_q  <= '0;
            yt_q <= '0;
          end else begin
            y_q  <= y_q + GW'(1);
            yt_q <= yt_q + AW'(g_q);
          end
        end else begin
          b_q  <= '0;
          y_q  <= ys_q;
          yt_q <= yts_q;
          c_q  <= c_q + SW'(1);
          if (z_q == g_m1) begin
            z_q  <= '0;
            zt_q <= '0;
          end else begin
            z_q  <= z_q + GW'(1);
            zt_q <= zt_q + AW'(g2_q);
          end
        end
      end
    end
  end

  assign sts_o.mod_last  = (mcnt_q == vsl_pkg::MCNT_W'(CW - 1));
  assign sts_o.dec_done  = (a_q == e_w);
  assign sts_o.walk_last = a_last && b_last && c_last;

  // stage 0: address and squared offset of the current cell
  logic [EW-1:0]  off_a, off_b, off_c;
  logic [AW-1:0]  addr0;
  logic [R2W-1:0] r2_d;

  function automatic logic [EW-1:0] abs_off(logic [SW-1:0] s, logic [SW-1:0] e);
    if (s >= e) return EW'(s - e);
    return EW'(e - s);
  endfunction

  always_comb begin
    off_a = abs_off(a_q, e_w);
    off_b = abs_off(b_q, e_w);
    off_c = abs_off(c_q, e_w);
    r2_d  = R2W'(off_a) * R2W'(off_a) + R2W'(off_b) * R2W'(off_b)
          + R2W'(off_c) * R2W'(off_c);
    addr0 = AW'(x_q) + yt_q + zt_q;
  end

  // pipeline: stage 1 reads the memory, stage 2 merges and writes back
  logic           vld1_q, rd1_q, vld2_q, rd2_q, fwd_q;
  logic [AW-1:0]  addr1_q, addr2_q;
  logic [R2W-1:0] r2_q;
  logic [LW-1:0]  v2_q, rdata_q, fwd_data_q;
  logic [DW-1:0]  rad, ep1, diff;
  logic [LW-1:0]  v1, old2, new2;

  always_comb begin
    rad = '0;
    for (int m = 1; m <= EMAX + 1; m++) begin
      if (int'(r2_q) >= m * m) rad = DW'(m);
    end
    ep1  = DW'(e_q) + DW'(1);
    diff = ep1 - rad;
    if (rad > DW'(e_q)) v1 = '0;
    else if (int'(diff) > int'(vsl_pkg::LEVEL_TOP)) v1 = vsl_pkg::LEVEL_TOP;
    else v1 = LW'(diff);
  end

  // back-to-back hits on one cell take the value just written
  assign old2 = fwd_q ? fwd_data_q : rdata_q;
  assign new2 = (v2_q > old2) ? v2_q : old2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      rd1_q  <= 1'b0;
      vld2_q <= 1'b0;
      rd2_q  <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      vld1_q <= cmd_i.walk_step;
      rd1_q  <= cmd_i.rd_issue;
      vld2_q <= vld1_q;
      rd2_q  <= rd1_q;
      fwd_q  <= vld2_q && vld1_q && (addr1_q == addr2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q    <= addr0;
    r2_q       <= r2_d;
    addr2_q    <= addr1_q;
    v2_q       <= v1;
    fwd_data_q <= new2;
  end

  // clear sweep
  logic [AW-1:0] clr_q;
  logic [LW-1:0] fill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_start) begin
      clr_q  <= '0;
      fill_q <= cmd_i.clr_zero ? '0 : base_level_q;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(CELL_COUNT - 1));

  // level memory: one write port, one registered read port
  logic [LW-1:0] mem [CELL_COUNT];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;

  always_comb begin
    mem_we    = cmd_i.clr_step || vld2_q;
    mem_waddr = cmd_i.clr_step ? clr_q : addr2_q;
    mem_wdata = cmd_i.clr_step ? fill_q : new2;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[addr1_q];
  end

  assign valid_o = rd2_q;
  assign level_o = old2;

endmodule

`default_nettype wire

/* hw/rtl/voxel_sphere_level_stamp.sv */
// voxel_sphere_level_stamp: top level of the periodic 3D level stamp.
// Depends on vsl_pkg, vsl_ctrl and vsl_dp.
//
// Usage:
//   Command channel: a request is taken on a rising edge with start_i high
//   and busy_o low. func_i selects clear (0), stamp (1) or read (2); code 3
//   is taken and does nothing. cell_x_i/y_i/z_i give the cell.
//   Result channel: a read gives one level on level_o, flagged by valid_o
//   for exactly one cycle; there is no back-pressure.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high. Index 0 grid_size, 1 num_levels,
//   2 base_level; other indexes are dropped. Write only while idle.
// Sequences (e = stamp extent, N = GRID_SIDE**3):
//   read : reduce the cell, form its address, read the memory, then flag valid_o.
//   stamp: walks (2e+1)**3 cells, one cell per cycle through a
//          read-modify-write on the single level memory.
//   clear: writes all N memory words, one memory word written per cycle.
// Reset: the sweep that zeroes the level memory keeps busy_o high
//   until it ends; config writes are taken meanwhile.
`default_nettype none

module voxel_sphere_level_stamp #(
  parameter int GRID_SIDE  = 64,
  parameter int MAX_LEVELS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        func_i,
  input  wire logic [vsl_pkg::COORD_W-1:0]       cell_x_i,
  input  wire logic [vsl_pkg::COORD_W-1:0]       cell_y_i,
  input  wire logic [vsl_pkg::COORD_W-1:0]       cell_z_i,
  output logic                                   valid_o,
  output logic [vsl_pkg::LVL_W-1:0]              level_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [vsl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [vsl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  vsl_pkg::cmd_t cmd;
  vsl_pkg::sts_t sts;
  logic          cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  vsl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  vsl_dp #(
    .GRID_SIDE  (GRID_SIDE),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .level_o     (level_o)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// testbench: self-checking bench for voxel_sphere_level_stamp (clear, stamp, read on a
// periodic level grid). Needs vsl_pkg and the block's RTL; keeps its own level grid model.
`timescale 1ns / 100ps

class level_scoreboard;
  localparam int SIDE_MAX  = 64;
  localparam int LEVEL_MAX = 8;
  localparam int CELLS     = SIDE_MAX * SIDE_MAX * SIDE_MAX;

  bit [2:0] cells [CELLS];
  bit [6:0] grid_size;
  bit [3:0] num_levels;
  bit [2:0] base_level;
  bit [2:0] expected_levels [$];
  int       errors;

  function new();
    grid_size  = 7'd64;
    num_levels = 4'd8;
    base_level = 3'd0;
    errors     = 0;
    foreach (cells[n]) cells[n] = 3'd0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [6:0] data);
    case (idx)
      vsl_pkg::CFG_GRID_SIZE:  grid_size  = data;
      vsl_pkg::CFG_NUM_LEVELS: num_levels = data[3:0];
      vsl_pkg::CFG_BASE_LEVEL: base_level = data[2:0];
      default: ;
    endcase
  endfunction

  function int side();
    if (grid_size == 0) return 1;
    if (grid_size > SIDE_MAX) return SIDE_MAX;
    return grid_size;
  endfunction

  function int extent();
    int n;
    n = num_levels;
    if (n < 2) n = 2;
    if (n > LEVEL_MAX) n = LEVEL_MAX;
    return n - 2;
  endfunction

  function int wrap(int c, int g);
    int p;
    p = c % g;
    if (p < 0) p += g;
    return p;
  endfunction

  function void stamp_ball(int cx, int cy, int cz);
    int g, e, i, j, k, d, v, idx;
    g = side();
    e = extent();
    for (k = -e; k <= e; k++)
      for (j = -e; j <= e; j++)
        for (i = -e; i <= e; i++) begin
          d = 0;
          while ((d + 1) * (d + 1) <= i * i + j * j + k * k) d++;
          v = (d <= e) ? e + 1 - d : 0;
          if (v > 7) v = 7;
          idx = wrap(cx + i, g) + g * (wrap(cy + j, g) + g * wrap(cz + k, g));
          if (cells[idx] < v) cells[idx] = v[2:0];
        end
  endfunction

  function void note_request(logic [1:0] func, logic [5:0] x, logic [5:0] y, logic [5:0] z);
    int g, rx, ry, rz;
    g  = side();
    rx = x % g;
    ry = y % g;
    rz = z % g;
    if (func == vsl_pkg::FUNC_CLEAR) begin
      foreach (cells[n]) cells[n] = base_level;
    end else if (func == vsl_pkg::FUNC_STAMP) begin
      stamp_ball(rx, ry, rz);
    end else if (func == vsl_pkg::FUNC_READ) begin
      expected_levels.push_back(cells[rx + g * (ry + g * rz)]);
    end
  endfunction

  function void check_level(logic [2:0] got);
    bit [2:0] want;
    if (expected_levels.size() == 0) begin
      if (errors < 10) $display("unexpected level %0d with no read pending", got);
      errors++;
      return;
    end
    want = expected_levels.pop_front();
    if (got !== want) begin
      if (errors < 10) $display("level mismatch: expected %0d got %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module testbench;

  localparam logic [1:0] FUNC_NOP   = 2'd3;   // unused code, taken and dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         DRAIN      = 2300;   // longer than the slowest stamp
  localparam int         LIMIT      = 5000000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start_i;
  logic                           busy_o;
  logic [1:0]                     func_i;
  logic [vsl_pkg::COORD_W-1:0]    cell_x_i, cell_y_i, cell_z_i;
  logic                           valid_o;
  logic [vsl_pkg::LVL_W-1:0]      level_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [vsl_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [vsl_pkg::CFG_DATA_W-1:0] cfg_data_i;

  level_scoreboard sb = new();
  int idle_pct = 11;
  int cycles   = 0;

  voxel_sphere_level_stamp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .valid_o     (valid_o),
    .level_o     (level_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[voxel_sphere_level_stamp] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_level(level_o);
  end

  // start_i is left high after a request is taken; the next call keeps or drops it
  task automatic issue_request(logic [1:0] func, logic [5:0] x, logic [5:0] y, logic [5:0] z);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i  <= 1'b1;
    func_i   <= func;
    cell_x_i <= x;
    cell_y_i <= y;
    cell_z_i <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(func, x, y, z);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stamps give no result, so wait out the longest one before touching config
  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic [5:0] near_coord(int c, int g, int e);
    int p;
    p = (c % g + int'($urandom_range(2 * e)) - e + 8 * g) % g;
    if ($urandom_range(1) && p + g <= 63) p += g;
    return p[5:0];
  endfunction

  initial begin
    int ph, n, r, g, e;
    logic [5:0] cx, cy, cz;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    func_i      <= vsl_pkg::FUNC_CLEAR;
    cell_x_i    <= '0;
    cell_y_i    <= '0;
    cell_z_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= vsl_pkg::CFG_GRID_SIZE;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full-size ball wrapping over the low corner, then the far corner
    write_reg(CFG_UNUSED, 7'h55);
    issue_request(vsl_pkg::FUNC_READ, 6'd0, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_STAMP, 6'd0, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_READ, 6'd0, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_READ, 6'd63, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_READ, 6'd58, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_READ, 6'd0, 6'd57, 6'd0);
    issue_request(vsl_pkg::FUNC_READ, 6'd3, 6'd3, 6'd3);
    issue_request(vsl_pkg::FUNC_STAMP, 6'd63, 6'd63, 6'd63);
    issue_request(vsl_pkg::FUNC_READ, 6'd63, 6'd63, 6'd63);
    issue_request(FUNC_NOP, 6'd63, 6'd63, 6'd63);
    issue_request(vsl_pkg::FUNC_READ, 6'd1, 6'd1, 6'd1);
    wait_idle();

    // tiny grid: ball folds onto itself, coordinates reduced
    write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd3);
    issue_request(vsl_pkg::FUNC_STAMP, 6'd62, 6'd5, 6'd9);
    issue_request(vsl_pkg::FUNC_READ, 6'd63, 6'd63, 6'd63);
    issue_request(vsl_pkg::FUNC_READ, 6'd2, 6'd2, 6'd0);
    wait_idle();

    // clear to the top level; a stamp cannot raise anything
    write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd64);
    write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd2);
    write_reg(vsl_pkg::CFG_BASE_LEVEL, 7'd7);
    issue_request(vsl_pkg::FUNC_CLEAR, 6'd5, 6'd6, 6'd7);
    issue_request(vsl_pkg::FUNC_READ, 6'd17, 6'd40, 6'd63);
    issue_request(vsl_pkg::FUNC_STAMP, 6'd17, 6'd40, 6'd63);
    issue_request(vsl_pkg::FUNC_READ, 6'd17, 6'd40, 6'd63);
    wait_idle();

    // upper data bits of base_level are dropped
    write_reg(vsl_pkg::CFG_BASE_LEVEL, 7'b1111001);
    write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd3);
    issue_request(vsl_pkg::FUNC_CLEAR, 6'd0, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_READ, 6'd0, 6'd0, 6'd0);
    issue_request(vsl_pkg::FUNC_STAMP, 6'd10, 6'd20, 6'd30);
    issue_request(vsl_pkg::FUNC_READ, 6'd10, 6'd20, 6'd30);
    issue_request(vsl_pkg::FUNC_READ, 6'd11, 6'd20, 6'd30);

    cx = 6'd10;
    cy = 6'd20;
    cz = 6'd30;
    for (ph = 0; ph < 9; ph++) begin
      wait_idle();
      idle_pct = (ph < 3) ? 11 : (ph < 6) ? 68 : 0;
      case (ph)
        0: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd64);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd8);
        end
        1: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd5);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd8);
        end
        2: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd1);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd2);
        end
        3: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd0);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd4);
        end
        4: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd127);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd3);
          write_reg(vsl_pkg::CFG_BASE_LEVEL, 7'd0);
        end
        5: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd13);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd15);
        end
        6: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd2);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd1);
        end
        7: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd64);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd0);
        end
        default: begin
          write_reg(vsl_pkg::CFG_GRID_SIZE, 7'd37);
          write_reg(vsl_pkg::CFG_NUM_LEVELS, 7'd6);
        end
      endcase
      g = sb.side();
      e = sb.extent();
      for (n = 0; n < 30; n++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          issue_request(FUNC_NOP, 6'($urandom), 6'($urandom), 6'($urandom));
        end else if (r < 38) begin
          cx = 6'($urandom);
          cy = 6'($urandom);
          cz = 6'($urandom);
          issue_request(vsl_pkg::FUNC_STAMP, cx, cy, cz);
        end else if (r < 70) begin
          // reads around the last ball hit its shells
          issue_request(vsl_pkg::FUNC_READ, near_coord(cx, g, e), near_coord(cy, g, e),
                        near_coord(cz, g, e));
        end else begin
          issue_request(vsl_pkg::FUNC_READ, 6'($urandom), 6'($urandom), 6'($urandom));
        end
      end
    end

    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[voxel_sphere_level_stamp] OK");
    end else begin
      $display("[voxel_sphere_level_stamp] ERROR");
    end
    $finish;
  end
endmodule
